>>> design/mtkg_pkg.sv
// Package for the MT19937 keystream generator.
// Holds the generator constants, the seeder handoff type and the twist/temper functions.
// No dependencies.
package mtkg_pkg;

  localparam int unsigned MT_N = 624;
  localparam int unsigned MT_M = 397;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W = $clog2(MT_N);

  localparam logic [WORD_W-1:0] MT_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] MT_UPPER = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MT_LOWER = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] MT_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

  // Seeder to chain: busy while pushing seeded words into the tail
  typedef struct packed {
    logic              busy;
    logic [WORD_W-1:0] word;
  } seed_push_t;

  // One twist step from the head word, its neighbor and the far tap
  function automatic logic [WORD_W-1:0] mt_twist(
    input logic [WORD_W-1:0] a,
    input logic [WORD_W-1:0] b,
    input logic [WORD_W-1:0] far
  );
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] r;
    y = (a & MT_UPPER) | (b & MT_LOWER);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ MT_MATRIX;
    end
    return r;
  endfunction

  // Output tempering
  function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> design/mtkg_if.sv
// Valid/ready channel interfaces for the keystream generator.
// Input channel carries data_byte; output channel carries masked_byte and random_word.
// Depends on mtkg_pkg.
interface mtkg_in_if;
  logic                       valid;
  logic                       ready;
  logic [mtkg_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mtkg_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtkg_pkg::BYTE_W-1:0] masked_byte;
  logic [mtkg_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output masked_byte, output random_word, input ready);
  modport sink (input valid, input masked_byte, input random_word, output ready);
endinterface

>>> design/mt19937_keystream_generator.sv
// MT19937 keystream generator, top level.
// Builds the 624-cell state chain, the seeder and the registered output stage.
// Depends on mtkg_pkg, mtkg_if, mtkg_cell and mtkg_seeder.

// The 624-word generator state lives in a chain of 32-bit cells that shifts by
// one cell per produced word: the head, its neighbor and the cell 397 places on
// feed the twist, the new word enters at the tail and its tempered value is the
// result. One byte is taken per clock cycle, a result waits in an output
// register, and besides seeding the input is held off only while that
// register is full and not being drained. After reset, and after every
// write to seed, the seeder pushes the 624 seeded words into the chain one
// per cycle; no byte is accepted while it does so.
module mt19937_keystream_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        seed_we,
  input  logic [mtkg_pkg::WORD_W-1:0] seed_data,
  mtkg_in_if.sink                     in_ch,
  mtkg_out_if.source                  out_ch
);
  import mtkg_pkg::*;

  seed_push_t        push;
  logic [WORD_W-1:0] stage [MT_N];
  logic [WORD_W-1:0] tail;
  logic [WORD_W-1:0] fresh;
  logic [WORD_W-1:0] tempered;
  logic              in_beat;
  logic              shift;
  logic              out_valid;
  logic [BYTE_W-1:0] masked_byte;
  logic [WORD_W-1:0] random_word;

  mtkg_seeder u_seeder (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (seed_we),
    .seed_data (seed_data),
    .push      (push)
  );

  // Handshake: stall while seeding or while the result is unread
  assign in_ch.ready = !push.busy && (!out_valid || out_ch.ready);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign shift       = push.busy || in_beat;

  // Twist of the head word, then tempering
  assign fresh    = mt_twist(stage[0], stage[1], stage[MT_M]);
  assign tempered = mt_temper(fresh);
  assign tail     = push.busy ? push.word : fresh;

  // State chain
  for (genvar k = 0; k < MT_N; k++) begin : g_chain
    if (k == MT_N - 1) begin : g_tail
      mtkg_cell u_cell (.clk(clk), .shift(shift), .d(tail), .q(stage[k]));
    end else begin : g_body
      mtkg_cell u_cell (.clk(clk), .shift(shift), .d(stage[k+1]), .q(stage[k]));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      random_word <= tempered;
      masked_byte <= in_ch.data_byte ^ tempered[BYTE_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.masked_byte = masked_byte;
  assign out_ch.random_word = random_word;

endmodule

>>> design/mtkg_cell.sv
// One 32-bit stage of the state shift chain.
// Loads its neighbor's word whenever the chain advances.
// Depends on mtkg_pkg.
module mtkg_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [mtkg_pkg::WORD_W-1:0] d,
  output logic [mtkg_pkg::WORD_W-1:0] q
);
  import mtkg_pkg::*;

  // Stage register, no reset: contents come from seeding
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

>>> design/mtkg_seeder.sv
// Seed register and seeding sequencer.
// Produces w[0]=seed, w[i]=MULT*(w[i-1]^(w[i-1]>>30))+i, one word per cycle.
// Depends on mtkg_pkg.
module mtkg_seeder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        seed_we,
  input  logic [mtkg_pkg::WORD_W-1:0] seed_data,
  output mtkg_pkg::seed_push_t        push
);
  import mtkg_pkg::*;

  logic              busy;
  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] word;

  // Recurrence: one constant multiply, then add the index
  always_comb begin
    mix  = prev ^ (prev >> 30);
    prod = mix * MT_MULT;
    if (idx == '0) begin
      word = seed;
    end else begin
      word = prod + {{(WORD_W-IDX_W){1'b0}}, idx};
    end
  end

  assign push.busy = busy;
  assign push.word = word;

  // Control: a seed write restarts the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      idx  <= '0;
      seed <= SEED_RESET;
    end else if (seed_we) begin
      busy <= 1'b1;
      idx  <= '0;
      seed <= seed_data;
    end else if (busy) begin
      idx <= idx + 1'b1;
      if (idx == IDX_W'(MT_N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Last pushed word feeds the next step
  always_ff @(posedge clk) begin
    if (busy) begin
      prev <= word;
    end
  end

endmodule

>>> bench/mtkg_checker.sv
// Scoreboard for the MT19937 keystream generator: watches the seed port and both channels.
// Keeps its own generator state, predicts each output beat and compares it field by field.
// Depends on mtkg_pkg.
module mtkg_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        seed_we,
  input  logic [mtkg_pkg::WORD_W-1:0] seed_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [mtkg_pkg::BYTE_W-1:0] in_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mtkg_pkg::BYTE_W-1:0] out_masked,
  input  logic [mtkg_pkg::WORD_W-1:0] out_word,
  output int                          fail_count,
  output int                          pending
);
  import mtkg_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] masked_byte;
    logic [WORD_W-1:0] random_word;
  } keystream_beat_t;

  logic [WORD_W-1:0] gen_state [MT_N];
  int unsigned       gen_index;
  keystream_beat_t   expected_beats [$];
  int                failures = 0;

  // Fill the whole state from a seed; next draw twists first
  task automatic seed_state(input logic [WORD_W-1:0] s);
    gen_state[0] = s;
    for (int unsigned i = 1; i < MT_N; i++) begin
      gen_state[i] = MT_MULT * (gen_state[i-1] ^ (gen_state[i-1] >> 30)) + i;
    end
    gen_index = MT_N;
  endtask

  // In-place twist over all 624 words (late words see already updated far taps)
  task automatic regenerate_state();
    logic [WORD_W-1:0] y;
    for (int unsigned k = 0; k < MT_N; k++) begin
      y = (gen_state[k] & MT_UPPER) | (gen_state[(k + 1) % MT_N] & MT_LOWER);
      gen_state[k] = gen_state[(k + MT_M) % MT_N] ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
    end
    gen_index = 0;
  endtask

  function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & MT_TEMPER_B);
    t = t ^ ((t << 15) & MT_TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  // One accepted byte consumes one tempered word
  task automatic draw_expected(input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] w;
    keystream_beat_t   beat;
    if (gen_index >= MT_N) regenerate_state();
    w = temper_word(gen_state[gen_index]);
    gen_index++;
    beat.masked_byte = b ^ w[BYTE_W-1:0];
    beat.random_word = w;
    expected_beats.push_back(beat);
  endtask

  task automatic flag(input string msg);
    failures++;
    if (failures <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    keystream_beat_t want;
    if (rst) begin
      seed_state(SEED_RESET);
      expected_beats.delete();
    end else begin
      // Output side first: a beat leaving now belongs to an older input
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_beats.size() == 0) begin
          flag($sformatf("unexpected beat, masked %h word %h", out_masked, out_word));
        end else begin
          want = expected_beats.pop_front();
          if (out_masked !== want.masked_byte)
            flag($sformatf("masked_byte expected %h, got %h", want.masked_byte, out_masked));
          if (out_word !== want.random_word)
            flag($sformatf("random_word expected %h, got %h", want.random_word, out_word));
        end
      end
      if (seed_we === 1'b1) seed_state(seed_data);
      if (in_valid === 1'b1 && in_ready === 1'b1) draw_expected(in_byte);
    end
    fail_count <= failures;
    pending <= expected_beats.size();
  end

endmodule

>>> bench/tb.sv
// Testbench top for the MT19937 keystream generator: clock, reset, seed writes and byte stimulus.
// Prediction and comparison live in mtkg_checker; the verdict is given here.
// Depends on mtkg_pkg, mtkg_if, mtkg_checker and the generator RTL.
module tb;
  import mtkg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              seed_we = 1'b0;
  logic [WORD_W-1:0] seed_data = '0;
  logic              src_valid = 1'b0;
  logic [BYTE_W-1:0] src_byte = '0;
  logic              sink_ready = 1'b0;
  int                tx_idle_pct = 11;
  int                rx_idle_pct = 52;
  int                cycles = 0;
  int                fail_count;
  int                pending;

  mtkg_in_if  in_ch ();
  mtkg_out_if out_ch ();

  assign in_ch.valid = src_valid;
  assign in_ch.data_byte = src_byte;
  assign out_ch.ready = sink_ready;

  mt19937_keystream_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (seed_we),
    .seed_data (seed_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  mtkg_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_data  (seed_data),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.data_byte),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_masked (out_ch.masked_byte),
    .out_word   (out_ch.random_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Stop offering and wait for every predicted beat to come out
  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] s);
    seed_we <= 1'b1;
    seed_data <= s;
    @(posedge clk);
    seed_we <= 1'b0;
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset seed: byte extremes, checkerboards, walking ones and zeros
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h55);
    send_byte(8'haa);
    for (int i = 0; i < BYTE_W; i++) send_byte(BYTE_W'(1) << i);
    for (int i = 0; i < BYTE_W; i++) send_byte(~(BYTE_W'(1) << i));
    send_random(300);

    // Seed extremes, then a random seed long enough to cross a twist, then seed 1
    drain();
    write_seed(32'h0000_0000);
    send_random(300);

    drain();
    set_idle(52, 11);
    write_seed(32'hffff_ffff);
    send_random(350);

    drain();
    set_idle(0, 0);
    write_seed($urandom);
    send_random(700);

    drain();
    write_seed(32'h0000_0001);
    send_random(50);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
